// File: rtl/lce_pkg.sv
// ----------------------------------------------------------------------------
// lce_pkg
// Shared types for the LRU cache with expiry: request and response payloads,
// status and action codes, per-entry operation codes and flags.
// ----------------------------------------------------------------------------
package lce_pkg;

  localparam int KeyW   = 64;
  localparam int ValW   = 64;
  localparam int TimeW  = 32;
  localparam int StatW  = 3;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_INSERT = 1'b1
  } action_t;

  typedef enum logic [StatW-1:0] {
    ST_MISS     = 3'd0,
    ST_HIT      = 3'd1,
    ST_EXPIRED  = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_INSERTED = 3'd4,
    ST_EVICTED  = 3'd5
  } status_t;

  typedef struct packed {
    action_t          action;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  new_value;
    logic [TimeW-1:0] now;
  } req_t;

  typedef struct packed {
    status_t         status;
    logic [ValW-1:0] found_value;
  } rsp_t;

  // operation broadcast to every entry cell
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_TOUCH  = 2'd1,
    OP_DROP   = 2'd2,
    OP_INSERT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     use_last;  // target is the least-recent entry, not the key match
    logic     wr_key;
    logic     wr_val;
  } cell_cmd_t;

  typedef struct packed {
    logic match;
    logic expired;
    logic last;
    logic free;
  } cell_flags_t;

endpackage

// File: rtl/lce_chan_if.sv
// ----------------------------------------------------------------------------
// lce_chan_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface lce_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lce_cell.sv
// ----------------------------------------------------------------------------
// lce_cell
// One cache entry: key, value, stamp, valid and recency rank. Compares the
// request against its entry when a transaction is taken, then applies the
// broadcast operation. The free chain finds the lowest-numbered free entry.
// ----------------------------------------------------------------------------
module lce_cell import lce_pkg::*; #(
  parameter int              RW        = 4,
  parameter logic [RW-1:0]   LAST_RANK = '1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  req_t              req,
  input  logic [TimeW-1:0]  ttl,
  input  cell_cmd_t         cmd,
  input  logic [RW-1:0]     ref_rank,
  input  logic              free_in,
  output logic              free_out,
  output cell_flags_t       flags,
  output logic [RW-1:0]     rank,
  output logic [ValW-1:0]   value
);

  logic             valid_r, valid_nxt;
  logic             match_r, exp_r, last_r;
  logic [KeyW-1:0]  key_r;
  logic [ValW-1:0]  value_r;
  logic [TimeW-1:0] stamp_r;
  logic [RW-1:0]    rank_r, rank_nxt;
  logic             tgt, ins_tgt, wr_here;

  assign tgt      = cmd.use_last ? last_r : match_r;
  assign ins_tgt  = !valid_r && !free_in;
  assign free_out = free_in || !valid_r;
  assign wr_here  = ((cmd.op == OP_TOUCH) && tgt) || ((cmd.op == OP_INSERT) && ins_tgt);

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    case (cmd.op)
      OP_TOUCH: begin
        if (tgt) begin
          rank_nxt = '0;
        end else if (valid_r && rank_r < ref_rank) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      OP_DROP: begin
        if (tgt) begin
          valid_nxt = 1'b0;
        end else if (valid_r && rank_r > ref_rank) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      OP_INSERT: begin
        if (ins_tgt) begin
          valid_nxt = 1'b1;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
      exp_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (load) begin
        match_r <= valid_r && (key_r == req.key);
        // age wraps modulo 2^32; equal to ttl is still fresh
        exp_r   <= (req.now - stamp_r) > ttl;
        last_r  <= valid_r && (rank_r == LAST_RANK);
      end
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    if (wr_here) begin
      stamp_r <= req.now;
      if (cmd.wr_key) key_r   <= req.key;
      if (cmd.wr_val) value_r <= req.new_value;
    end
  end

  assign flags.match   = match_r;
  assign flags.expired = exp_r;
  assign flags.last    = last_r;
  assign flags.free    = !valid_r;
  assign rank          = rank_r;
  assign value         = value_r;

endmodule

// File: rtl/lru_cache_with_expiry.sv
// ----------------------------------------------------------------------------
// lru_cache_with_expiry
// Fully associative key/value cache with LRU replacement and TTL expiry,
// built as a row of entry cells sharing a broadcast request.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          handshake
//  in_ch    in   action, key, new_value, now      valid/ready
//  out_ch   out  status, found_value              valid/ready
//  cfg_ch   in   ttl_seconds (32 bits)            valid/ready, always ready
//
//  Each transaction has a compare cycle, where every cell matches the key
//  and checks age in parallel, then an update cycle, where the ranks shift
//  and the result is registered. rst_n clears valid bits, entry count and
//  sets ttl to 3600. A stalled result holds the update cycle until out_ch
//  has room; no new transaction is taken meanwhile.
// ----------------------------------------------------------------------------
module lru_cache_with_expiry import lce_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lce_chan_if.sink   in_ch,
  lce_chan_if.source out_ch,
  lce_chan_if.sink   cfg_ch
);

  localparam int            RW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int            CW        = $clog2(CAPACITY + 1);
  localparam logic [RW-1:0] LAST_RANK = RW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  state_t           state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_data_r, out_data_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [TimeW-1:0] ttl_r, ttl_nxt;
  req_t             req_r;

  logic             accept, fire;
  cell_cmd_t        cmd;
  logic [RW-1:0]    ref_rank;
  cell_flags_t      flags [CAPACITY];
  logic [RW-1:0]    ranks [CAPACITY];
  logic [ValW-1:0]  values [CAPACITY];
  logic [CAPACITY:0] free_chain;
  logic [CAPACITY-1:0] match_vec, valid_vec;

  logic             hit, exp_hit;
  logic [RW-1:0]    hit_rank;
  logic [ValW-1:0]  hit_value;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign fire         = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign free_chain[0] = 1'b0;

  // request held for the update cycle; cells compare against the live input
  always_ff @(posedge clk) begin
    if (accept) req_r <= in_ch.data;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lce_cell #(
      .RW        (RW),
      .LAST_RANK (LAST_RANK)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (accept),
      .req      (accept ? in_ch.data : req_r),
      .ttl      (ttl_r),
      .cmd      (cmd),
      .ref_rank (ref_rank),
      .free_in  (free_chain[i]),
      .free_out (free_chain[i+1]),
      .flags    (flags[i]),
      .rank     (ranks[i]),
      .value    (values[i])
    );
    assign match_vec[i] = flags[i].match;
    assign valid_vec[i] = !flags[i].free;
  end

  // keys are unique, so at most one cell matches: plain OR select
  always_comb begin
    hit       = 1'b0;
    exp_hit   = 1'b0;
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit       = hit | flags[i].match;
      exp_hit   = exp_hit | (flags[i].match & flags[i].expired);
      hit_rank  = hit_rank | (ranks[i] & {RW{flags[i].match}});
      hit_value = hit_value | (values[i] & {ValW{flags[i].match}});
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    count_nxt     = count_r;
    ttl_nxt       = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : ttl_r;
    cmd           = '{op: OP_NONE, use_last: 1'b0, wr_key: 1'b0, wr_val: 1'b0};
    ref_rank      = hit_rank;

    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (fire) begin
          state_nxt                = S_IDLE;
          out_valid_nxt            = 1'b1;
          out_data_nxt.found_value = '0;
          if (req_r.action == ACT_LOOKUP) begin
            if (!hit) begin
              out_data_nxt.status = ST_MISS;
            end else if (exp_hit) begin
              cmd.op              = OP_DROP;
              count_nxt           = count_r - 1'b1;
              out_data_nxt.status = ST_EXPIRED;
            end else begin
              cmd.op                   = OP_TOUCH;
              out_data_nxt.status      = ST_HIT;
              out_data_nxt.found_value = hit_value;
            end
          end else if (hit) begin
            cmd.op              = OP_TOUCH;
            cmd.wr_val          = 1'b1;
            out_data_nxt.status = ST_UPDATED;
          end else if (count_r != FULL_CNT) begin
            cmd.op              = OP_INSERT;
            cmd.wr_key          = 1'b1;
            cmd.wr_val          = 1'b1;
            count_nxt           = count_r + 1'b1;
            out_data_nxt.status = ST_INSERTED;
          end else begin
            // full: reuse the least-recent entry regardless of its age
            cmd.op              = OP_TOUCH;
            cmd.use_last        = 1'b1;
            cmd.wr_key          = 1'b1;
            cmd.wr_val          = 1'b1;
            ref_rank            = LAST_RANK;
            out_data_nxt.status = ST_EVICTED;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      ttl_r       <= TimeW'(3600);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      ttl_r       <= ttl_nxt;
    end
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == count_r)
    else $error("entry count differs from number of valid cells");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(match_vec))
    else $error("more than one cell matched the key");

  a_one_free_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && count_r != FULL_CNT) |-> free_chain[CAPACITY])
    else $error("not full but no free cell found");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && state_r == S_IDLE)
    else $error("update cycle did not register a result");
`endif

endmodule
